@@ sv/pbhs_pkg.sv @@
`timescale 1ns / 1ps

package pbhs_pkg;

   // default width of the length counters
   localparam int LEN_BITS_DEF = 17;

   // varint accumulator: five full digits give the 32-bit field number above the wire type
   localparam int ACC_BITS = 35;
   localparam logic [3:0] ACC_DIGITS = 4'(ACC_BITS / 7);
   localparam logic [3:0] LAST_DIGIT = 4'd9;
   localparam logic [3:0] CNT_LIMIT = 4'd10;

   localparam logic [2:0] WIRE_LEN_DELIM = 3'd2;
   localparam logic [31:0] FIELD_KEY = 32'd1;
   localparam logic [31:0] FIELD_SIG = 32'd2;
   localparam logic [31:0] FIELD_EXT = 32'd4;
   localparam logic [31:0] FIELD_MUX = 32'd2;

   typedef enum logic [1:0] {
      PH_KEY   = 2'd0,
      PH_LEN   = 2'd1,
      PH_BODY  = 2'd2,
      PH_FIRST = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      FK_OTHER = 2'd0,
      FK_KEY   = 2'd1,
      FK_SIG   = 2'd2,
      FK_EXT   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ROLE_HEADER = 3'd0,
      ROLE_KEY    = 3'd1,
      ROLE_SIG    = 3'd2,
      ROLE_MUX    = 3'd3,
      ROLE_SKIP   = 3'd4
   } role_type;

   typedef enum logic [3:0] {
      ST_RUN          = 4'd0,
      ST_OK           = 4'd1,
      ST_BAD_VARINT   = 4'd2,
      ST_INCOMPLETE   = 4'd3,
      ST_BAD_WIRE     = 4'd4,
      ST_OVERRUN      = 4'd5,
      ST_BAD_EXT_WIRE = 4'd6,
      ST_EXT_OVERRUN  = 4'd7,
      ST_MISSING      = 4'd8
   } status_type;

   typedef enum logic [1:0] {
      VI_MORE = 2'd0,
      VI_DONE = 2'd1,
      VI_BAD  = 2'd2
   } varint_res_type;

   typedef struct packed {
      logic [ACC_BITS-1:0] acc;
      logic                big;
      logic [3:0]          cnt;
      varint_res_type      res;
   } varint_type;

   typedef struct packed {
      logic [7:0] echo;
      role_type   role;
      logic       elem_start;
      logic       elem_end;
      status_type status;
   } rsp_type;

   // one varint digit: low digits go into the accumulator, higher ones only flag a large value
   function automatic varint_type varint_step(input logic [ACC_BITS-1:0] acc,
                                              input logic                big,
                                              input logic [3:0]          cnt,
                                              input logic [7:0]          b);
      varint_type          r;
      logic [ACC_BITS-1:0] part;
      logic [3:0]          cnt_nx;
      r.acc  = acc;
      r.big  = big;
      r.cnt  = cnt;
      r.res  = VI_MORE;
      part   = {{(ACC_BITS-7){1'b0}}, b[6:0]} << (6'(cnt) * 6'd7);
      cnt_nx = cnt + 4'd1;
      priority if (cnt < ACC_DIGITS) begin
         r.acc = acc | part;
      end else if (cnt < LAST_DIGIT) begin
         r.big = big | (|b[6:0]);
      end else if (cnt == LAST_DIGIT) begin
         r.big = big | b[0];
      end else begin
         // past the tenth digit the varint has already failed
         r.big = big;
      end
      if (!b[7]) begin
         r.res = VI_DONE;
      end else begin
         r.cnt = cnt_nx;
         if (cnt_nx >= CNT_LIMIT) begin
            r.res = VI_BAD;
         end
      end
      return r;
   endfunction

endpackage

@@ sv/protobuf_handshake_payload_parser_unit.sv @@
`timescale 1ns / 1ps

// Streaming parser for a decrypted handshake payload in protobuf wire format. One byte enters
// per cycle on req_ (req_tlast on the final byte) while req_tready is high, and one tagged word
// leaves per byte on rsp_ from a registered output. The key/length varint decoders and the outer
// and extension length counters update on each accepted byte. A two-word output buffer (result
// register plus skid) keeps req_tready high while one result waits.
// Each output word echoes the byte with its role (header, identity key, signature, muxer
// name, skipped), start/end marks of fields and muxer entries, and the parse status, which
// reads running until the last byte or an error, then ok or an error code. Errors stay until reset;
// after a good payload the parser starts over for the next one.
module protobuf_handshake_payload_parser_unit #(
   parameter int LEN_BITS = pbhs_pkg::LEN_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic [15:0] rsp_tdata,   // [7:0] echo_byte, [11:8] parse_status, [15:12] zero
   output logic [4:0]  rsp_tuser,   // [2:0] byte_role, [3] element_start, [4] element_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready
);

   localparam int AB = pbhs_pkg::ACC_BITS;

   // outer parser state
   pbhs_pkg::phase_type   outer_phase_ff, outer_phase_in;
   logic [AB-1:0]         outer_acc_ff, outer_acc_in;
   logic                  outer_big_ff, outer_big_in;
   logic [3:0]            outer_cnt_ff, outer_cnt_in;
   pbhs_pkg::kind_type    outer_kind_ff, outer_kind_in;
   logic [LEN_BITS-1:0]   outer_rem_ff, outer_rem_in;
   // extension parser state
   pbhs_pkg::phase_type   inner_phase_ff, inner_phase_in;
   logic [AB-1:0]         inner_acc_ff, inner_acc_in;
   logic                  inner_big_ff, inner_big_in;
   logic [3:0]            inner_cnt_ff, inner_cnt_in;
   logic                  inner_mux_ff, inner_mux_in;
   logic [LEN_BITS-1:0]   inner_rem_ff, inner_rem_in;
   // flags and errors
   logic                  key_seen_ff, key_seen_in;
   logic                  sig_seen_ff, sig_seen_in;
   pbhs_pkg::status_type  sticky_ff, sticky_in;
   pbhs_pkg::status_type  ext_pend_ff, ext_pend_in;

   // output buffer
   pbhs_pkg::rsp_type     out_ff, skid_ff, res;
   logic                  out_valid_ff, skid_valid_ff;

   pbhs_pkg::varint_type  ov, iv;
   pbhs_pkg::status_type  err;
   logic                  done;
   logic [LEN_BITS-1:0]   rem_dec, irem_dec;
   logic                  push, pop;
   logic [31:0]           ofield, ifield;

   assign push       = req_tvalid & req_tready;
   assign pop        = rsp_tvalid & rsp_tready;
   assign req_tready = ~skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_ff.status, out_ff.echo};
   assign rsp_tuser  = {out_ff.elem_end, out_ff.elem_start, out_ff.role};

   assign ov       = pbhs_pkg::varint_step(outer_acc_ff, outer_big_ff, outer_cnt_ff, req_tdata);
   assign iv       = pbhs_pkg::varint_step(inner_acc_ff, inner_big_ff, inner_cnt_ff, req_tdata);
   assign rem_dec  = outer_rem_ff - LEN_BITS'(1);
   assign irem_dec = inner_rem_ff - LEN_BITS'(1);
   assign ofield   = ov.acc[AB-1:3];
   assign ifield   = iv.acc[AB-1:3];

   // parser next state and result word
   always_comb begin
      outer_phase_in = outer_phase_ff;
      outer_acc_in   = outer_acc_ff;
      outer_big_in   = outer_big_ff;
      outer_cnt_in   = outer_cnt_ff;
      outer_kind_in  = outer_kind_ff;
      outer_rem_in   = outer_rem_ff;
      inner_phase_in = inner_phase_ff;
      inner_acc_in   = inner_acc_ff;
      inner_big_in   = inner_big_ff;
      inner_cnt_in   = inner_cnt_ff;
      inner_mux_in   = inner_mux_ff;
      inner_rem_in   = inner_rem_ff;
      key_seen_in    = key_seen_ff;
      sig_seen_in    = sig_seen_ff;
      sticky_in      = sticky_ff;
      ext_pend_in    = ext_pend_ff;
      err            = pbhs_pkg::ST_RUN;
      done           = 1'b0;
      res.echo       = req_tdata;
      res.role       = pbhs_pkg::ROLE_HEADER;
      res.elem_start = 1'b0;
      res.elem_end   = 1'b0;
      res.status     = pbhs_pkg::ST_RUN;

      if (sticky_ff != pbhs_pkg::ST_RUN) begin
         res.status = sticky_ff;
      end else begin
         unique case (outer_phase_ff)
            // field key varint
            pbhs_pkg::PH_KEY: begin
               outer_acc_in = ov.acc;
               outer_big_in = ov.big;
               outer_cnt_in = ov.cnt;
               if (ov.res == pbhs_pkg::VI_BAD) begin
                  err = pbhs_pkg::ST_BAD_VARINT;
               end else if (ov.res == pbhs_pkg::VI_DONE) begin
                  outer_acc_in = '0;
                  outer_big_in = 1'b0;
                  outer_cnt_in = '0;
                  if (ov.acc[2:0] != pbhs_pkg::WIRE_LEN_DELIM) begin
                     err = pbhs_pkg::ST_BAD_WIRE;
                  end else begin
                     outer_phase_in = pbhs_pkg::PH_LEN;
                     priority if (ofield == pbhs_pkg::FIELD_KEY) begin
                        outer_kind_in = pbhs_pkg::FK_KEY;
                     end else if (ofield == pbhs_pkg::FIELD_SIG) begin
                        outer_kind_in = pbhs_pkg::FK_SIG;
                     end else if (ofield == pbhs_pkg::FIELD_EXT) begin
                        outer_kind_in = pbhs_pkg::FK_EXT;
                     end else begin
                        outer_kind_in = pbhs_pkg::FK_OTHER;
                     end
                  end
               end
               if (err == pbhs_pkg::ST_RUN && req_tlast) begin
                  err = pbhs_pkg::ST_INCOMPLETE;
               end
            end
            // field length varint
            pbhs_pkg::PH_LEN: begin
               outer_acc_in = ov.acc;
               outer_big_in = ov.big;
               outer_cnt_in = ov.cnt;
               unique case (ov.res)
                  pbhs_pkg::VI_BAD: begin
                     err = pbhs_pkg::ST_BAD_VARINT;
                  end
                  pbhs_pkg::VI_MORE: begin
                     if (req_tlast) begin
                        err = pbhs_pkg::ST_INCOMPLETE;
                     end
                  end
                  pbhs_pkg::VI_DONE: begin
                     outer_acc_in = '0;
                     outer_big_in = 1'b0;
                     outer_cnt_in = '0;
                     if (ov.big || (|ov.acc[AB-1:LEN_BITS-1])) begin
                        err = pbhs_pkg::ST_OVERRUN;
                     end else begin
                        if (outer_kind_ff == pbhs_pkg::FK_KEY) begin
                           key_seen_in = (ov.acc != '0);
                        end
                        if (outer_kind_ff == pbhs_pkg::FK_SIG) begin
                           sig_seen_in = (ov.acc != '0);
                        end
                        if (ov.acc == '0) begin
                           outer_phase_in = pbhs_pkg::PH_KEY;
                           done           = req_tlast;
                        end else begin
                           outer_rem_in   = ov.acc[LEN_BITS-1:0];
                           outer_phase_in = pbhs_pkg::PH_FIRST;
                           inner_phase_in = pbhs_pkg::PH_KEY;
                           inner_acc_in   = '0;
                           inner_big_in   = 1'b0;
                           inner_cnt_in   = '0;
                           inner_mux_in   = 1'b0;
                           inner_rem_in   = '0;
                           ext_pend_in    = pbhs_pkg::ST_RUN;
                           if (req_tlast) begin
                              err = pbhs_pkg::ST_OVERRUN;
                           end
                        end
                     end
                  end
                  default: begin
                     err = pbhs_pkg::ST_BAD_VARINT;
                  end
               endcase
            end
            // field content
            pbhs_pkg::PH_BODY, pbhs_pkg::PH_FIRST: begin
               res.elem_start = (outer_phase_ff == pbhs_pkg::PH_FIRST);
               res.elem_end   = (rem_dec == '0);
               outer_rem_in   = rem_dec;
               unique case (outer_kind_ff)
                  pbhs_pkg::FK_KEY:   res.role = pbhs_pkg::ROLE_KEY;
                  pbhs_pkg::FK_SIG:   res.role = pbhs_pkg::ROLE_SIG;
                  pbhs_pkg::FK_OTHER: res.role = pbhs_pkg::ROLE_SKIP;
                  pbhs_pkg::FK_EXT: begin
                     if (ext_pend_ff != pbhs_pkg::ST_RUN) begin
                        res.role = pbhs_pkg::ROLE_SKIP;
                     end else if (inner_phase_ff == pbhs_pkg::PH_KEY ||
                                  inner_phase_ff == pbhs_pkg::PH_LEN) begin
                        // extension entry key or length
                        inner_acc_in = iv.acc;
                        inner_big_in = iv.big;
                        inner_cnt_in = iv.cnt;
                        if (iv.res == pbhs_pkg::VI_BAD) begin
                           ext_pend_in = pbhs_pkg::ST_BAD_VARINT;
                        end else if (iv.res == pbhs_pkg::VI_DONE) begin
                           inner_acc_in = '0;
                           inner_big_in = 1'b0;
                           inner_cnt_in = '0;
                           if (inner_phase_ff == pbhs_pkg::PH_KEY) begin
                              if (iv.acc[2:0] != pbhs_pkg::WIRE_LEN_DELIM) begin
                                 ext_pend_in = pbhs_pkg::ST_BAD_EXT_WIRE;
                              end else begin
                                 inner_mux_in   = (ifield == pbhs_pkg::FIELD_MUX);
                                 inner_phase_in = pbhs_pkg::PH_LEN;
                              end
                           end else if (iv.big ||
                                        iv.acc > {{(AB-LEN_BITS){1'b0}}, rem_dec}) begin
                              ext_pend_in = pbhs_pkg::ST_EXT_OVERRUN;
                           end else if (iv.acc == '0) begin
                              inner_phase_in = pbhs_pkg::PH_KEY;
                           end else begin
                              inner_rem_in   = iv.acc[LEN_BITS-1:0];
                              inner_phase_in = pbhs_pkg::PH_FIRST;
                           end
                        end
                     end else begin
                        // extension entry content
                        res.role = inner_mux_ff ? pbhs_pkg::ROLE_MUX : pbhs_pkg::ROLE_SKIP;
                        if (inner_mux_ff && inner_phase_ff == pbhs_pkg::PH_FIRST) begin
                           res.elem_start = 1'b1;
                        end
                        if (inner_mux_ff && irem_dec == '0) begin
                           res.elem_end = 1'b1;
                        end
                        inner_rem_in   = irem_dec;
                        inner_phase_in = (irem_dec == '0) ? pbhs_pkg::PH_KEY : pbhs_pkg::PH_BODY;
                     end
                     // extension errors come out on the last byte of the field
                     if (rem_dec == '0) begin
                        if (ext_pend_in == pbhs_pkg::ST_RUN &&
                            (inner_phase_in != pbhs_pkg::PH_KEY || inner_cnt_in != '0)) begin
                           ext_pend_in = pbhs_pkg::ST_INCOMPLETE;
                        end
                        err = ext_pend_in;
                     end
                  end
                  default: res.role = pbhs_pkg::ROLE_SKIP;
               endcase
               outer_phase_in = (rem_dec == '0) ? pbhs_pkg::PH_KEY : pbhs_pkg::PH_BODY;
               if (err == pbhs_pkg::ST_RUN && req_tlast) begin
                  if (rem_dec != '0) begin
                     err = pbhs_pkg::ST_OVERRUN;
                  end else begin
                     done = 1'b1;
                  end
               end
            end
            default: begin
               err = pbhs_pkg::ST_BAD_VARINT;
            end
         endcase

         // final status at the end of the payload
         if (err == pbhs_pkg::ST_RUN && done && !(key_seen_in && sig_seen_in)) begin
            err = pbhs_pkg::ST_MISSING;
         end
         if (err != pbhs_pkg::ST_RUN) begin
            sticky_in  = err;
            res.status = err;
         end else if (done) begin
            res.status     = pbhs_pkg::ST_OK;
            outer_phase_in = pbhs_pkg::PH_KEY;
            outer_acc_in   = '0;
            outer_big_in   = 1'b0;
            outer_cnt_in   = '0;
            outer_kind_in  = pbhs_pkg::FK_OTHER;
            outer_rem_in   = '0;
            key_seen_in    = 1'b0;
            sig_seen_in    = 1'b0;
         end
      end
   end

   // parser state, updated on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         outer_phase_ff <= pbhs_pkg::PH_KEY;
         outer_acc_ff   <= '0;
         outer_big_ff   <= 1'b0;
         outer_cnt_ff   <= '0;
         outer_kind_ff  <= pbhs_pkg::FK_OTHER;
         outer_rem_ff   <= '0;
         inner_phase_ff <= pbhs_pkg::PH_KEY;
         inner_acc_ff   <= '0;
         inner_big_ff   <= 1'b0;
         inner_cnt_ff   <= '0;
         inner_mux_ff   <= 1'b0;
         inner_rem_ff   <= '0;
         key_seen_ff    <= 1'b0;
         sig_seen_ff    <= 1'b0;
         sticky_ff      <= pbhs_pkg::ST_RUN;
         ext_pend_ff    <= pbhs_pkg::ST_RUN;
      end else if (push) begin
         outer_phase_ff <= outer_phase_in;
         outer_acc_ff   <= outer_acc_in;
         outer_big_ff   <= outer_big_in;
         outer_cnt_ff   <= outer_cnt_in;
         outer_kind_ff  <= outer_kind_in;
         outer_rem_ff   <= outer_rem_in;
         inner_phase_ff <= inner_phase_in;
         inner_acc_ff   <= inner_acc_in;
         inner_big_ff   <= inner_big_in;
         inner_cnt_ff   <= inner_cnt_in;
         inner_mux_ff   <= inner_mux_in;
         inner_rem_ff   <= inner_rem_in;
         key_seen_ff    <= key_seen_in;
         sig_seen_ff    <= sig_seen_in;
         sticky_ff      <= sticky_in;
         ext_pend_ff    <= ext_pend_in;
      end
   end

   // output register and skid word valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end
         out_valid_ff <= 1'b1;
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   // output register and skid word payload
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_ff <= res;
         end else begin
            out_ff <= res;
         end
      end
   end

endmodule
